@@ hdl/kct_pkg.sv @@
package kct_pkg;

    // Table geometry
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int OCC_W   = $clog2(ENTRIES + 1);

    // Field widths
    localparam int KEY_W   = 32;
    localparam int CNT_W   = 31;
    localparam int TOT_W   = 38;
    localparam int TOTO_W  = 37;
    localparam int USED_W  = 7;
    localparam int ENTRY_W = KEY_W + CNT_W;

    // Operation codes; code 3 is unused and leaves the table alone
    typedef enum logic [1:0] {
        KIND_SET = 2'd0,
        KIND_GET = 2'd1,
        KIND_DEL = 2'd2
    } kind_t;

    // Result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADJ,
        ST_DONE
    } state_t;

    // One stored entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] cnt;
    } entry_t;

    // One result, engine to output stage
    typedef struct packed {
        logic [CNT_W-1:0]  count_out;
        logic              status;
        logic [TOTO_W-1:0] total_count;
        logic [USED_W-1:0] used_entries;
    } res_t;

endpackage

@@ hdl/kct_ram.sv @@
module kct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/kct_engine.sv @@
module kct_engine
    import kct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       kind,
    input  logic [KEY_W-1:0] key,
    input  logic [CNT_W-1:0] count,
    output logic             idle,
    input  logic             res_ready,
    output logic             res_valid,
    output res_t             res
);

    state_t state_reg, state_next;

    logic [1:0]         kind_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   iss_reg;
    logic               iss_on_reg;
    logic               chk_on_reg;
    logic [IDX_W-1:0]   chk_idx_reg;
    logic               chk_vbit_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [CNT_W-1:0]   hit_cnt_reg;
    logic               free_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [TOT_W-1:0]   total_reg;
    logic [OCC_W-1:0]   occ_reg;

    logic               rd_en;
    logic               chk_last;
    logic               fire;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    entry_t             rd_data;
    logic               match;
    logic               is_set;
    logic               is_get;
    logic               is_del;
    logic               stored;
    logic               insert;
    logic               full;
    logic               del_hit;
    logic [CNT_W-1:0]   add_amt;
    logic [TOT_W-1:0]   total_sum;
    logic [OCC_W-1:0]   occ_new;

    // Entry store: key and count side by side
    kct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (iss_reg),
        .rd_data (rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chk_last)
                begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        idle      = 1'b0;
        rd_en     = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: idle      = 1'b1;
            ST_SCAN: rd_en     = iss_on_reg;
            ST_ADJ:  ;
            ST_DONE: res_valid = 1'b1;
            default: ;
        endcase
    end

    // Operation decode and result
    always_comb
    begin
        is_set   = (kind_reg == KIND_SET);
        is_get   = (kind_reg == KIND_GET);
        is_del   = (kind_reg == KIND_DEL);
        chk_last = chk_on_reg && (chk_idx_reg == IDX_W'(ENTRIES - 1));
        match    = chk_on_reg && chk_vbit_reg && (rd_data.key == key_reg);
        fire     = res_valid && res_ready;
        stored   = is_set && (hit_reg || free_reg);
        insert   = is_set && !hit_reg && free_reg;
        full     = is_set && !hit_reg && !free_reg;
        del_hit  = is_del && hit_reg;

        add_amt   = stored ? cnt_reg : '0;
        total_sum = total_reg + TOT_W'(add_amt);
        occ_new   = occ_reg;
        if (insert)
        begin
            occ_new = occ_reg + OCC_W'(1);
        end
        else if (del_hit)
        begin
            occ_new = occ_reg - OCC_W'(1);
        end

        wr_en       = fire && stored;
        wr_addr     = hit_reg ? hit_idx_reg : free_idx_reg;
        wr_data.key = key_reg;
        wr_data.cnt = cnt_reg;

        res.count_out    = stored ? cnt_reg : ((is_get && hit_reg) ? hit_cnt_reg : '0);
        res.status       = full ? STATUS_FULL : STATUS_OK;
        res.total_count  = TOTO_W'(total_sum);
        res.used_entries = USED_W'(occ_new);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            iss_reg    <= '0;
            iss_on_reg <= 1'b0;
            chk_on_reg <= 1'b0;
            hit_reg    <= 1'b0;
            free_reg   <= 1'b0;
            valid_reg  <= '0;
            total_reg  <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            chk_on_reg <= rd_en;

            // Request taken: start the scan at slot zero
            if (idle && start)
            begin
                iss_reg    <= '0;
                iss_on_reg <= 1'b1;
                hit_reg    <= 1'b0;
                free_reg   <= 1'b0;
            end

            // Issue one read per cycle, note the lowest free slot
            if (rd_en)
            begin
                if (iss_reg == IDX_W'(ENTRIES - 1))
                begin
                    iss_on_reg <= 1'b0;
                end
                else
                begin
                    iss_reg <= iss_reg + IDX_W'(1);
                end
                if (!valid_reg[iss_reg] && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
            end

            if (match)
            begin
                hit_reg <= 1'b1;
            end

            // Take out the old count of a matched entry
            if ((state_reg == ST_ADJ) && (is_set || is_del) && hit_reg)
            begin
                total_reg <= total_reg - TOT_W'(hit_cnt_reg);
            end

            // Commit
            if (fire)
            begin
                total_reg <= total_sum;
                occ_reg   <= occ_new;
                if (insert)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                end
                if (del_hit)
                begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (idle && start)
        begin
            kind_reg <= kind;
            key_reg  <= key;
            cnt_reg  <= count;
        end
        if (rd_en)
        begin
            chk_idx_reg  <= iss_reg;
            chk_vbit_reg <= valid_reg[iss_reg];
            if (!valid_reg[iss_reg] && !free_reg)
            begin
                free_idx_reg <= iss_reg;
            end
        end
        if (match)
        begin
            hit_idx_reg <= chk_idx_reg;
            hit_cnt_reg <= rd_data.cnt;
        end
    end

endmodule

@@ hdl/key_count_table.sv @@
// Channel  Handshake           Payload
// input    in_valid/in_ready   kind, key, count
// output   out_valid/out_ready count_out, status, total_count, used_entries
//
// Each request scans the whole table before out_valid: one read per slot from
// the entry RAM, the registered RAM read, a step that removes the old count
// from the total, and a commit that loads the result register. The engine
// then returns to idle before it takes the next request.
// One request is in flight at a time; in_ready is high only when idle.
// A waiting result holds the commit until the output register frees up.
// Reset empties the table at once through the per-slot valid flops.
module key_count_table
    import kct_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               kind,
    input  logic signed [KEY_W-1:0]  key,
    input  logic [CNT_W-1:0]         count,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [CNT_W-1:0]         count_out,
    output logic                     status,
    output logic [TOTO_W-1:0]        total_count,
    output logic [USED_W-1:0]        used_entries
);

    logic eng_idle;
    logic eng_res_valid;
    logic slot_free;
    res_t eng_res;
    logic out_valid_reg;
    res_t out_data_reg;

    assign in_ready  = eng_idle;
    assign slot_free = !out_valid_reg || out_ready;

    kct_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid),
        .kind      (kind),
        .key       (key),
        .count     (count),
        .idle      (eng_idle),
        .res_ready (slot_free),
        .res_valid (eng_res_valid),
        .res       (eng_res)
    );

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= eng_res_valid;
        end
    end

    // Output register data
    always_ff @(posedge clk)
    begin
        if (slot_free && eng_res_valid)
        begin
            out_data_reg <= eng_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign count_out    = out_data_reg.count_out;
    assign status       = out_data_reg.status;
    assign total_count  = out_data_reg.total_count;
    assign used_entries = out_data_reg.used_entries;

endmodule

@@ bench/key_count_table_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the key/count table. Keeps a shadow copy of the
// table, predicts each result when a request is taken, and compares results
// in order.
module key_count_table_checker
    import kct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [1:0]        kind,
    input  logic [KEY_W-1:0]  key,
    input  logic [CNT_W-1:0]  count,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [CNT_W-1:0]  count_out,
    input  logic              status,
    input  logic [TOTO_W-1:0] total_count,
    input  logic [USED_W-1:0] used_entries,
    output int                mismatches,
    output int                outstanding,
    output int                results_seen,
    output int                full_seen
);

    // Shadow table
    logic [KEY_W-1:0]  slot_key   [ENTRIES];
    logic [CNT_W-1:0]  slot_count [ENTRIES];
    logic              slot_used  [ENTRIES];
    logic [TOT_W-1:0]  sum_of_counts;
    logic [USED_W-1:0] used_slots;

    res_t expected_results [$];
    res_t next_expected;

    function automatic int find_slot(logic [KEY_W-1:0] k);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (slot_used[i] && slot_key[i] == k)
                return i;
        end
        return -1;
    endfunction

    function automatic int first_free_slot();
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!slot_used[i])
                return i;
        end
        return -1;
    endfunction

    // Applies one request to the shadow table and returns its result
    function automatic res_t apply_to_table(logic [1:0] op, logic [KEY_W-1:0] k,
                                            logic [CNT_W-1:0] c);
        res_t r;
        int   slot;
        r = '0;
        r.status = STATUS_OK;
        slot = find_slot(k);
        case (op)
            KIND_SET:
            begin
                if (slot >= 0)
                begin
                    // overwrite in place, total moves by the difference
                    sum_of_counts = sum_of_counts - slot_count[slot] + c;
                    slot_count[slot] = c;
                    r.count_out = c;
                end
                else
                begin
                    slot = first_free_slot();
                    if (slot >= 0)
                    begin
                        slot_key[slot]   = k;
                        slot_count[slot] = c;
                        slot_used[slot]  = 1'b1;
                        sum_of_counts    = sum_of_counts + c;
                        used_slots       = used_slots + 1'b1;
                        r.count_out      = c;
                    end
                    else
                        r.status = STATUS_FULL;
                end
            end
            KIND_GET:
            begin
                if (slot >= 0)
                    r.count_out = slot_count[slot];
            end
            KIND_DEL:
            begin
                if (slot >= 0)
                begin
                    sum_of_counts   = sum_of_counts - slot_count[slot];
                    slot_used[slot] = 1'b0;
                    used_slots      = used_slots - 1'b1;
                end
            end
            default: ;  // unused code: table untouched
        endcase
        r.total_count  = sum_of_counts[TOTO_W-1:0];
        r.used_entries = used_slots;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_key[i]   = '0;
                slot_count[i] = '0;
                slot_used[i]  = 1'b0;
            end
            sum_of_counts = '0;
            used_slots    = '0;
            expected_results.delete();
            mismatches   = 0;
            results_seen = 0;
            full_seen    = 0;
            outstanding <= 0;
        end
        else
        begin
            // compare a taken result with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: count_out %0d status %0d total %0d used %0d",
                           count_out, status, total_count, used_entries);
                    mismatches++;
                end
                else
                begin
                    next_expected = expected_results.pop_front();
                    results_seen++;
                    if (count_out !== next_expected.count_out)
                    begin
                        $error("count_out: expected %0d, got %0d",
                               next_expected.count_out, count_out);
                        mismatches++;
                    end
                    if (status !== next_expected.status)
                    begin
                        $error("status: expected %0d, got %0d", next_expected.status, status);
                        mismatches++;
                    end
                    if (total_count !== next_expected.total_count)
                    begin
                        $error("total_count: expected %0d, got %0d",
                               next_expected.total_count, total_count);
                        mismatches++;
                    end
                    if (used_entries !== next_expected.used_entries)
                    begin
                        $error("used_entries: expected %0d, got %0d",
                               next_expected.used_entries, used_entries);
                        mismatches++;
                    end
                    if (next_expected.status == STATUS_FULL)
                        full_seen++;
                end
            end

            // predict the result of a taken request
            if (in_valid && in_ready)
                expected_results.push_back(apply_to_table(kind, key, count));

            outstanding <= expected_results.size();
        end
    end

endmodule

@@ bench/key_count_table_tb.sv @@
`timescale 1ns / 100ps

module key_count_table_tb;
    import kct_pkg::*;

    localparam int RANDOM_REQUESTS = 750;
    localparam int STALL_LIMIT     = 2000;
    localparam int POOL_SIZE       = 96;

    localparam logic [1:0]       KIND_UNUSED = 2'd3;
    localparam logic [CNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [KEY_W-1:0] KEY_ALL_ONE = '1;
    localparam logic [KEY_W-1:0] KEY_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_NEG_MIN = 32'h8000_0000;

    // Mix of requests in one stretch of random traffic
    typedef enum int {PH_FILL, PH_CHURN, PH_DRAIN, PH_NOISE} phase_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        kind;
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  count;
    logic              out_valid;
    logic              out_ready;
    logic [CNT_W-1:0]  count_out;
    logic              status;
    logic [TOTO_W-1:0] total_count;
    logic [USED_W-1:0] used_entries;

    int mismatches;
    int outstanding;
    int results_seen;
    int full_seen;
    int requests_sent = 0;
    int directed_sent;
    int idle_cycles   = 0;
    bit no_idle       = 1'b0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    key_count_table uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .key          (key),
        .count        (count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .count_out    (count_out),
        .status       (status),
        .total_count  (total_count),
        .used_entries (used_entries)
    );

    key_count_table_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .key          (key),
        .count        (count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .count_out    (count_out),
        .status       (status),
        .total_count  (total_count),
        .used_entries (used_entries),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .full_seen    (full_seen)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        else
            return $urandom_range(30, 120);
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return COUNT_MAX;
        else if (r == 2)
            return CNT_W'($urandom_range(1, 15));
        else
            return CNT_W'($urandom());
    endfunction

    // Offer one request and hold it until taken
    task automatic drive_request(input logic [1:0] op, input logic [KEY_W-1:0] k,
                                 input logic [CNT_W-1:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= op;
        key      <= k;
        count    <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic run_phase(input phase_t style, input int n);
        int r;
        int set_lim;
        int get_lim;
        int del_lim;
        logic [KEY_W-1:0] k;
        case (style)
            PH_FILL:  begin set_lim = 75; get_lim = 90; del_lim = 95; end
            PH_CHURN: begin set_lim = 35; get_lim = 70; del_lim = 95; end
            PH_DRAIN: begin set_lim = 15; get_lim = 40; del_lim = 95; end
            default:  begin set_lim = 0;  get_lim = 0;  del_lim = 0;  end
        endcase
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                k = $urandom();
            else
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (r < set_lim)
                drive_request(KIND_SET, k, pick_count());
            else if (r < get_lim)
                drive_request(KIND_GET, k, CNT_W'($urandom()));
            else if (r < del_lim)
                drive_request(KIND_DEL, k, CNT_W'($urandom()));
            else
                drive_request(2'($urandom_range(0, 3)), $urandom(), CNT_W'($urandom()));
        end
    endtask

    // Result side: runs of ready broken by stalls
    initial
    begin
        int run_len;
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            run_len = $urandom_range(1, 20);
            out_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Watchdog: too long with no request or result taken
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        phase_t style;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        kind     = KIND_SET;
        key      = '0;
        count    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // key pool: extremes first, rest random; larger than the table
        key_pool[0] = '0;
        key_pool[1] = KEY_ALL_ONE;
        key_pool[2] = KEY_POS_MAX;
        key_pool[3] = KEY_NEG_MIN;
        key_pool[4] = 32'd1;
        for (int i = 5; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();

        // Directed: empty table, extremes, update, delete, unused code
        drive_request(KIND_GET,    '0,            '0);
        drive_request(KIND_DEL,    32'd5,         '0);
        drive_request(KIND_UNUSED, '0,            '0);
        drive_request(KIND_SET,    '0,            '0);
        drive_request(KIND_SET,    KEY_POS_MAX,   COUNT_MAX);
        drive_request(KIND_SET,    KEY_NEG_MIN,   COUNT_MAX);
        drive_request(KIND_SET,    KEY_ALL_ONE,   31'd1);
        drive_request(KIND_SET,    32'h5555_5555, 31'h2AAA_AAAA);
        drive_request(KIND_SET,    32'hAAAA_AAAA, 31'h5555_5555);
        drive_request(KIND_GET,    KEY_POS_MAX,   '0);
        drive_request(KIND_GET,    KEY_NEG_MIN,   COUNT_MAX);
        drive_request(KIND_GET,    '0,            '0);
        drive_request(KIND_GET,    32'h1234_5678, '0);
        drive_request(KIND_SET,    KEY_POS_MAX,   31'd7);
        drive_request(KIND_GET,    KEY_POS_MAX,   '0);
        drive_request(KIND_DEL,    KEY_NEG_MIN,   '0);
        drive_request(KIND_GET,    KEY_NEG_MIN,   '0);
        drive_request(KIND_DEL,    KEY_NEG_MIN,   '0);
        drive_request(KIND_SET,    KEY_NEG_MIN,   31'd3);
        drive_request(KIND_UNUSED, KEY_ALL_ONE,   COUNT_MAX);
        drive_request(KIND_DEL,    KEY_ALL_ONE,   '0);
        drive_request(KIND_GET,    '0,            COUNT_MAX);
        directed_sent = requests_sent;

        // Random: start with a stretch weighted to filling the table, then mixed stretches
        run_phase(PH_FILL, 100);
        while (requests_sent - directed_sent < RANDOM_REQUESTS)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            style = phase_t'($urandom_range(0, 3));
            case (style)
                PH_FILL:  run_phase(style, $urandom_range(40, 90));
                PH_CHURN: run_phase(style, $urandom_range(30, 80));
                PH_DRAIN: run_phase(style, $urandom_range(40, 90));
                default:  run_phase(style, $urandom_range(10, 25));
            endcase
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        // drain remaining results, then let the block settle; the count of
        // open predictions is registered, so it lags the last request
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (ENTRIES + 8) @(posedge clk);

        $display("Summary: %0d requests (%0d directed, rest random set/get/delete/unused)",
                 requests_sent, directed_sent);
        $display("Summary: %0d results checked, %0d table-full results, %0d mismatches",
                 results_seen, full_seen, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ key_count_table.f @@
hdl/kct_pkg.sv
hdl/kct_ram.sv
hdl/kct_engine.sv
hdl/key_count_table.sv
bench/key_count_table_checker.sv
bench/key_count_table_tb.sv
